// ===== rtl/core/ostt_pkg.sv =====
// Package for the one-shot timer table.
// Holds the request action codes, result status codes and field types.
// No dependencies.
package ostt_pkg;

    typedef logic [1:0]  action_t;
    typedef logic [2:0]  status_t;
    typedef logic [31:0] word_t;
    typedef logic [15:0] cb_t;
    typedef logic [3:0]  slot_t;

    // Request actions
    localparam action_t ACT_TICK   = 2'd0;
    localparam action_t ACT_CREATE = 2'd1;
    localparam action_t ACT_DELETE = 2'd2;

    // Result status codes
    localparam status_t ST_CREATED    = 3'd0;
    localparam status_t ST_BAD        = 3'd1;
    localparam status_t ST_FULL       = 3'd2;
    localparam status_t ST_DELETED    = 3'd3;
    localparam status_t ST_TICK_IDLE  = 3'd4;
    localparam status_t ST_TICK_FIRED = 3'd5;

endpackage

// ===== rtl/core/one_shot_timer_table_top.sv =====
// One-shot timer table, top level.
// Slot store, valid bits, tick counter and a scan sequencer around one shared adder.
// Depends on ostt_pkg.

// Each transaction yields one result. A delete or rejected request goes from
// acceptance to the pending result registers and then to the output register.
// A create walks the valid bits one slot a cycle; a tick walks the slot store
// one entry a cycle through its registered read port. A single 33-bit adder is
// shared: it forms the deadline tick + timeout on create and the compare
// tick >= deadline on tick. The input stalls while a transaction is in progress;
// a finished result waits in the output register, so the next request can be
// taken while it is held.
module one_shot_timer_table_top #(
    parameter int NUM_SLOTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ostt_pkg::action_t action,
    input  ostt_pkg::word_t   timeout,
    input  ostt_pkg::cb_t     callback_id,
    input  ostt_pkg::word_t   arg_value,
    input  ostt_pkg::slot_t   target_slot,
    output logic              out_valid,
    input  logic              out_stall,
    output ostt_pkg::status_t status,
    output ostt_pkg::slot_t   slot_out,
    output ostt_pkg::cb_t     fired_callback,
    output ostt_pkg::word_t   fired_arg,
    output ostt_pkg::word_t   tick_now
);

    import ostt_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1) + 1;
    localparam int XW = 8;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_TICK   = 2'd1;
    localparam logic [1:0] S_CREATE = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    localparam logic [CW-1:0] NUM_C  = CW'(NUM_SLOTS);
    localparam logic [IW-1:0] LAST_I = IW'(NUM_SLOTS - 1);

    // Control state
    logic [1:0]           state_reg, state_next;
    logic [CW-1:0]        scan_idx_reg, scan_idx_next;
    logic [IW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                 cmp_live_reg, cmp_live_next;
    logic [NUM_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    word_t                tick_count_reg, tick_count_next;
    logic                 out_valid_reg, out_valid_next;

    // Latched request and pending result
    word_t   timeout_reg, timeout_next;
    cb_t     cb_reg, cb_next;
    word_t   arg_reg, arg_next;
    status_t res_status_reg, res_status_next;
    slot_t   res_slot_reg, res_slot_next;
    cb_t     res_cb_reg, res_cb_next;
    word_t   res_arg_reg, res_arg_next;

    // Output register
    status_t out_status_reg;
    slot_t   out_slot_reg;
    cb_t     out_cb_reg;
    word_t   out_arg_reg;
    word_t   out_tick_reg;

    // Slot store
    word_t deadline_mem [NUM_SLOTS];
    cb_t   callback_mem [NUM_SLOTS];
    word_t arg_mem      [NUM_SLOTS];
    word_t rd_deadline_reg;
    cb_t   rd_cb_reg;
    word_t rd_arg_reg;
    logic  mem_we;
    logic  mem_re;
    logic [IW-1:0] mem_addr;

    // Shared adder
    word_t       add_b;
    logic        add_cin;
    logic [32:0] add_sum;
    logic        tick_ge;

    logic [XW-1:0] tgt_ext;
    logic [XW-1:0] idx_ext;
    logic          accept;
    logic          out_load;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign mem_addr = scan_idx_reg[IW-1:0];
    assign tgt_ext  = XW'(target_slot);
    assign idx_ext  = XW'(scan_idx_reg[IW-1:0]);

    // Shared adder: tick + timeout on create, tick - deadline borrow on tick
    always_comb
    begin
        if (state_reg == S_CREATE)
        begin
            add_b   = timeout_reg;
            add_cin = 1'b0;
        end
        else
        begin
            add_b   = ~rd_deadline_reg;
            add_cin = 1'b1;
        end
        add_sum = {1'b0, tick_count_reg} + {1'b0, add_b} + 33'(add_cin);
        tick_ge = add_sum[32];
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_live_next   = 1'b0;
        slot_valid_next = slot_valid_reg;
        tick_count_next = tick_count_reg;
        out_valid_next  = out_valid_reg;
        timeout_next    = timeout_reg;
        cb_next         = cb_reg;
        arg_next        = arg_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_cb_next     = res_cb_reg;
        res_arg_next    = res_arg_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    timeout_next    = timeout;
                    cb_next         = callback_id;
                    arg_next        = arg_value;
                    scan_idx_next   = '0;
                    res_slot_next   = '0;
                    res_cb_next     = '0;
                    res_arg_next    = '0;
                    unique case (action)
                        ACT_TICK:
                        begin
                            tick_count_next = tick_count_reg + 32'd1;
                            state_next      = S_TICK;
                        end
                        ACT_CREATE:
                        begin
                            if (callback_id == '0 || timeout == '0)
                            begin
                                res_status_next = ST_BAD;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_CREATE;
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (tgt_ext < XW'(NUM_SLOTS))
                            begin
                                slot_valid_next[tgt_ext[IW-1:0]] = 1'b0;
                            end
                            res_status_next = ST_DELETED;
                            state_next      = S_DONE;
                        end
                        default:
                        begin
                            res_status_next = ST_BAD;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end

            S_TICK:
            begin
                // Issue one read per cycle, compare the previous one
                if (scan_idx_reg < NUM_C)
                begin
                    mem_re        = 1'b1;
                    cmp_idx_next  = scan_idx_reg[IW-1:0];
                    cmp_live_next = 1'b1;
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
                if (cmp_live_reg && slot_valid_reg[cmp_idx_reg] && tick_ge)
                begin
                    slot_valid_next[cmp_idx_reg] = 1'b0;
                    res_status_next = ST_TICK_FIRED;
                    res_slot_next   = 4'(XW'(cmp_idx_reg));
                    res_cb_next     = rd_cb_reg;
                    res_arg_next    = rd_arg_reg;
                    cmp_live_next   = 1'b0;
                    state_next      = S_DONE;
                end
                else if (cmp_live_reg && cmp_idx_reg == LAST_I)
                begin
                    res_status_next = ST_TICK_IDLE;
                    cmp_live_next   = 1'b0;
                    state_next      = S_DONE;
                end
            end

            S_CREATE:
            begin
                // Walk valid bits for the lowest free slot
                if (!slot_valid_reg[scan_idx_reg[IW-1:0]])
                begin
                    mem_we = 1'b1;
                    slot_valid_next[scan_idx_reg[IW-1:0]] = 1'b1;
                    res_status_next = ST_CREATED;
                    res_slot_next   = idx_ext[3:0];
                    state_next      = S_DONE;
                end
                else if (scan_idx_reg[IW-1:0] == LAST_I)
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + CW'(1);
                end
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_idx_reg   <= '0;
            cmp_idx_reg    <= '0;
            cmp_live_reg   <= 1'b0;
            slot_valid_reg <= '0;
            tick_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_idx_reg    <= cmp_idx_next;
            cmp_live_reg   <= cmp_live_next;
            slot_valid_reg <= slot_valid_next;
            tick_count_reg <= tick_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        timeout_reg    <= timeout_next;
        cb_reg         <= cb_next;
        arg_reg        <= arg_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_cb_reg     <= res_cb_next;
        res_arg_reg    <= res_arg_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
            out_cb_reg     <= res_cb_reg;
            out_arg_reg    <= res_arg_reg;
            out_tick_reg   <= tick_count_reg;
        end
    end

    // Slot store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            deadline_mem[mem_addr] <= add_sum[31:0];
            callback_mem[mem_addr] <= cb_reg;
            arg_mem[mem_addr]      <= arg_reg;
        end
        if (mem_re)
        begin
            rd_deadline_reg <= deadline_mem[mem_addr];
            rd_cb_reg       <= callback_mem[mem_addr];
            rd_arg_reg      <= arg_mem[mem_addr];
        end
    end

    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = out_status_reg;
    assign slot_out       = out_slot_reg;
    assign fired_callback = out_cb_reg;
    assign fired_arg      = out_arg_reg;
    assign tick_now       = out_tick_reg;

endmodule

// ===== test/one_shot_timer_table_top_tb.sv =====
// Self-checking testbench for one_shot_timer_table_top (create, delete and tick requests).
// A clocked driver and monitor with random idling; a behavioral copy of the table predicts each result.
// Depends on ostt_pkg and the one_shot_timer_table_top RTL.
module one_shot_timer_table_top_tb;

    import ostt_pkg::*;

    localparam int NUM_SLOTS   = 16;
    localparam int QUIET_LIMIT = 3000;  // cycles with no transaction on either side
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_REQS = 1720;

    // Action code the block does not define; answered as a bad request
    localparam action_t ACT_UNUSED = 2'd3;

    typedef enum logic [1:0] {PACE_FREE, PACE_LIGHT, PACE_HEAVY} pace_t;

    typedef struct packed {
        action_t    action;
        word_t      timeout;
        cb_t        callback_id;
        word_t      arg_value;
        slot_t      target_slot;
        logic       wait_drain;  // hold this request until all results are back
        logic [7:0] gap;         // idle cycles after this request is accepted
    } timer_req_t;

    typedef struct packed {
        status_t status;
        slot_t   slot;
        cb_t     callback;
        word_t   arg;
        word_t   tick;
    } timer_result_t;

    logic    clk;
    logic    rst_n       = 1'b0;
    logic    in_valid    = 1'b0;
    logic    in_stall;
    action_t action      = ACT_TICK;
    word_t   timeout     = '0;
    cb_t     callback_id = '0;
    word_t   arg_value   = '0;
    slot_t   target_slot = '0;
    logic    out_valid;
    logic    out_stall   = 1'b0;
    status_t status;
    slot_t   slot_out;
    cb_t     fired_callback;
    word_t   fired_arg;
    word_t   tick_now;

    // Behavioral copy of the timer table
    word_t       tick_ctr;
    logic        slot_armed [NUM_SLOTS];
    word_t       slot_due   [NUM_SLOTS];
    cb_t         slot_tag   [NUM_SLOTS];
    word_t       slot_word  [NUM_SLOTS];

    timer_req_t    request_queue [$];
    timer_result_t results_due   [$];
    timer_req_t    cur_req;
    timer_result_t predicted;
    timer_result_t want;
    logic [7:0]    gap_left = '0;

    int unsigned requests_total = 0;
    int unsigned requests_sent  = 0;
    int unsigned results_seen   = 0;
    int unsigned status_hits [0:7];
    int          fail_count     = 0;

    pace_t       stall_pace;
    int unsigned pace_cycles_left;
    int unsigned stall_left;
    int unsigned stall_pick;

    one_shot_timer_table_top #(
        .NUM_SLOTS(NUM_SLOTS)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .timeout        (timeout),
        .callback_id    (callback_id),
        .arg_value      (arg_value),
        .target_slot    (target_slot),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .slot_out       (slot_out),
        .fired_callback (fired_callback),
        .fired_arg      (fired_arg),
        .tick_now       (tick_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one request to the table copy and return the result it should produce
    function automatic timer_result_t apply_timer_request(input timer_req_t req);
        timer_result_t res;
        logic          found;
        res   = '0;
        found = 1'b0;
        case (req.action)
            ACT_TICK:
            begin
                tick_ctr   = tick_ctr + 32'd1;
                res.status = ST_TICK_IDLE;
                // lowest armed slot that is due fires; at most one per tick
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!found && slot_armed[i] && tick_ctr >= slot_due[i])
                    begin
                        found         = 1'b1;
                        slot_armed[i] = 1'b0;
                        res.status    = ST_TICK_FIRED;
                        res.slot      = slot_t'(i);
                        res.callback  = slot_tag[i];
                        res.arg       = slot_word[i];
                    end
                end
            end
            ACT_CREATE:
            begin
                if (req.callback_id == '0 || req.timeout == '0)
                    res.status = ST_BAD;
                else
                begin
                    res.status = ST_FULL;
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (!found && !slot_armed[i])
                        begin
                            found         = 1'b1;
                            slot_armed[i] = 1'b1;
                            slot_tag[i]   = req.callback_id;
                            slot_word[i]  = req.arg_value;
                            slot_due[i]   = tick_ctr + req.timeout;  // wraps at 32 bits
                            res.status    = ST_CREATED;
                            res.slot      = slot_t'(i);
                        end
                    end
                end
            end
            ACT_DELETE:
            begin
                if (int'(req.target_slot) < NUM_SLOTS)
                    slot_armed[req.target_slot] = 1'b0;
                res.status = ST_DELETED;
            end
            default:
                res.status = ST_BAD;
        endcase
        res.tick = tick_ctr;
        return res;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] exp_val,
                                        input logic [31:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, exp_val, got_val);
            fail_count++;
        end
    endfunction

    function automatic logic [7:0] pick_gap(input pace_t pace);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (pace == PACE_FREE)
            return 8'd0;
        if (pace == PACE_LIGHT)
        begin
            if (r < 70)
                return 8'd0;
            if (r < 95)
                return 8'($urandom_range(1, 3));
            return 8'($urandom_range(10, 40));
        end
        if (r < 35)
            return 8'd0;
        if (r < 85)
            return 8'($urandom_range(1, 5));
        return 8'($urandom_range(10, 40));
    endfunction

    // Mostly short timers that fire soon; some long, some that wrap past 2^32
    function automatic word_t pick_timeout();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return word_t'($urandom_range(1, 6));
        if (r < 75)
            return word_t'($urandom_range(7, 300));
        if (r < 85)
            return word_t'($urandom);
        if (r < 95)
            return 32'hFFFF_FFFF - word_t'($urandom_range(0, 50));
        return 32'h8000_0000 + word_t'($urandom_range(0, 15));
    endfunction

    task automatic push_req(input action_t act, input word_t tmo, input cb_t cb,
                            input word_t arg, input slot_t slot);
        timer_req_t req;
        req             = '0;
        req.action      = act;
        req.timeout     = tmo;
        req.callback_id = cb;
        req.arg_value   = arg;
        req.target_slot = slot;
        request_queue.push_back(req);
    endtask

    task automatic queue_random_requests(input int count);
        timer_req_t  req;
        pace_t       pace;
        int unsigned r;
        pace = PACE_LIGHT;
        for (int n = 0; n < count; n++)
        begin
            if (n % 150 == 0)
                pace = pace_t'($urandom_range(0, 2));
            r               = $urandom_range(0, 99);
            req.timeout     = $urandom;
            req.callback_id = cb_t'($urandom);
            req.arg_value   = $urandom;
            req.target_slot = slot_t'($urandom);
            req.wait_drain  = (n % 400 == 0) || (n == count / 2);
            req.gap         = pick_gap(pace);
            if (r < 40)
                req.action = ACT_TICK;
            else if (r < 75)
            begin
                req.action      = ACT_CREATE;
                req.timeout     = pick_timeout();
                req.callback_id = cb_t'($urandom_range(1, 65535));
            end
            else if (r < 79)
            begin
                // malformed create: no handler or zero timeout
                req.action = ACT_CREATE;
                if ($urandom_range(0, 1) == 0)
                    req.callback_id = '0;
                else
                    req.timeout = '0;
            end
            else if (r < 96)
                req.action = ACT_DELETE;
            else
                req.action = ACT_UNUSED;
            request_queue.push_back(req);
        end
    endtask

    // Driver: present the next pending request once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= '0;
            tick_ctr = '0;
            for (int i = 0; i < NUM_SLOTS; i++)
                slot_armed[i] = 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predicted = apply_timer_request(cur_req);
                results_due.push_back(predicted);
                status_hits[predicted.status]++;
                requests_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 8'd1;
                    in_valid <= 1'b0;
                end
                else if (request_queue.size() != 0 &&
                         !(request_queue[0].wait_drain && results_due.size() != 0))
                begin
                    cur_req = request_queue.pop_front();
                    in_valid    <= 1'b1;
                    action      <= cur_req.action;
                    timeout     <= cur_req.timeout;
                    callback_id <= cur_req.callback_id;
                    arg_value   <= cur_req.arg_value;
                    target_slot <= cur_req.target_slot;
                    gap_left    <= cur_req.gap;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result transaction, and stall the output in random stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_pace       = PACE_FREE;
            pace_cycles_left = 0;
            stall_left       = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (results_due.size() == 0)
                begin
                    $error("result with no request outstanding: status %0d", status);
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("slot_out", 32'(want.slot), 32'(slot_out));
                    check_field("fired_callback", 32'(want.callback), 32'(fired_callback));
                    check_field("fired_arg", want.arg, fired_arg);
                    check_field("tick_now", want.tick, tick_now);
                end
            end
            if (pace_cycles_left == 0)
            begin
                stall_pace       = pace_t'($urandom_range(0, 2));
                pace_cycles_left = $urandom_range(100, 400);
            end
            else
                pace_cycles_left--;
            if (stall_left == 0)
            begin
                stall_pick = $urandom_range(0, 99);
                if (stall_pace == PACE_LIGHT && stall_pick < 15)
                    stall_left = $urandom_range(1, 3);
                else if (stall_pace == PACE_LIGHT && stall_pick < 18)
                    stall_left = $urandom_range(10, 30);
                else if (stall_pace == PACE_HEAVY && stall_pick < 40)
                    stall_left = $urandom_range(1, 6);
                else if (stall_pace == PACE_HEAVY && stall_pick < 48)
                    stall_left = $urandom_range(10, 40);
            end
            if (stall_left != 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog: end the run if neither side moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $error("no transaction for %0d cycles", QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus and end of run
    initial
    begin
        for (int i = 0; i < 8; i++)
            status_hits[i] = 0;

        // Directed: rejects, fire and free, deadline wrap, full table, delete
        push_req(ACT_TICK, '0, '0, '0, '0);
        push_req(ACT_CREATE, 32'd5, 16'h0000, 32'h1234_5678, '0);
        push_req(ACT_CREATE, 32'd0, 16'h0005, 32'h1234_5678, '0);
        push_req(ACT_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 4'hF);
        push_req(ACT_CREATE, 32'd1, 16'hFFFF, 32'hFFFF_FFFF, '0);
        push_req(ACT_DELETE, '0, '0, '0, 4'd15);
        push_req(ACT_TICK, '0, '0, '0, '0);
        push_req(ACT_CREATE, 32'hFFFF_FFFF, 16'h0001, 32'h0000_0000, '0);
        push_req(ACT_TICK, '0, '0, '0, '0);
        for (int i = 0; i < NUM_SLOTS; i++)
            push_req(ACT_CREATE, 32'h8000_0000, cb_t'(i + 1), word_t'(32'hA5A5_0000 + i), '0);
        push_req(ACT_CREATE, 32'd3, 16'h0BAD, 32'h0, '0);
        push_req(ACT_DELETE, '0, '0, '0, 4'd15);

        queue_random_requests(RANDOM_REQS);
        requests_total = request_queue.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_sent != requests_total || results_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (results_due.size() != 0)
        begin
            $error("%0d results never arrived", results_due.size());
            fail_count++;
        end
        $display("Covered %0d requests and %0d results: %0d created, %0d fired, %0d idle ticks,",
                 requests_sent, results_seen, status_hits[ST_CREATED],
                 status_hits[ST_TICK_FIRED], status_hits[ST_TICK_IDLE]);
        $display("  %0d deleted, %0d rejected as malformed, %0d rejected with the table full",
                 status_hits[ST_DELETED], status_hits[ST_BAD], status_hits[ST_FULL]);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ostt_pkg.sv
rtl/core/one_shot_timer_table_top.sv
test/one_shot_timer_table_top_tb.sv
